// ----- rtl/mvrh_pkg.sv -----
// Package for the median velocity core: sizes, constants, codes and the
// controller/datapath command and status structs. No dependencies.
package mvrh_pkg;

  localparam int HIST_DEPTH = 16;
  localparam int MAX_PAIRS  = 5;
  localparam int MIN_FRAMES = 5;

  localparam int DIST_W  = 16;
  localparam int STAMP_W = 32;
  localparam int VEL_W   = 32;
  localparam int DDB_W   = 8;
  localparam int VDB_W   = 10;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 10;

  localparam int PTR_W   = $clog2(HIST_DEPTH);
  localparam int FRM_W   = $clog2(HIST_DEPTH + 2);
  localparam int NP_W    = $clog2(MAX_PAIRS + 1);
  localparam int SCALE_W = 24;
  localparam int PROD_W  = DIST_W + SCALE_W;
  localparam int DCNT_W  = $clog2(PROD_W);
  localparam int SCNT_W  = $clog2(MAX_PAIRS + 1);

  localparam logic [STAMP_W-1:0] GAP_LOW   = STAMP_W'(1000);
  localparam logic [STAMP_W-1:0] GAP_HIGH  = STAMP_W'(50000);
  localparam logic [SCALE_W-1:0] SCALE_FIX = SCALE_W'(16000000);
  localparam logic [7:0]         FAIL_LIMIT = 8'd10;
  localparam logic [7:0]         FAIL_MAX   = 8'd255;
  localparam logic [DDB_W-1:0]   DDB_RESET  = DDB_W'(2);
  localparam logic [VDB_W-1:0]   VDB_RESET  = VDB_W'(5);

  localparam logic [CFG_IDX_W-1:0] REG_DIST_DB = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_VEL_DB  = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    OUT_FEW   = 2'd0,
    OUT_NONE  = 2'd1,
    OUT_STILL = 2'd2,
    OUT_MEAS  = 2'd3
  } outcome_t;

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_ADDR, S_CHK, S_MUL, S_DIV, S_STORE, S_SORT, S_FINISH
  } state_t;

  typedef struct packed {
    logic load;
    logic rd;
    logic take;
    logic skip;
    logic mul;
    logic div;
    logic store;
    logic sort;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic few;
    logic loop_go;
    logic gap_ok;
    logic div_last;
    logic sort_last;
    logic out_free;
  } stat_t;

endpackage

// ----- rtl/median_velocity_from_range_history_core.sv -----
// Top level of the median velocity core: controller plus datapath.
// Depends on mvrh_pkg, mvrh_ctrl, mvrh_dp.
//
//  channel  direction  handshake            word
//  in       input      in_valid/in_ready    distance_cm, stamp_us
//  out      output     out_valid/out_ready  velocity, calc_error, outcome
//  cfg      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// One word at a time. Under 5 frames the word goes straight to the finish step.
// Otherwise each even history slot is checked, each valid pair runs a 40-step
// restoring divider, and then 5 sort passes run.
// Sync reset clears history pointer, counts, flags and loads register defaults.
// A result held in the output register lets the next word in; the finish step
// waits only if that register is still full. cfg is always ready.
module median_velocity_from_range_history_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [mvrh_pkg::DIST_W-1:0]       distance_cm,
  input  logic [mvrh_pkg::STAMP_W-1:0]      stamp_us,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [mvrh_pkg::VEL_W-1:0] velocity,
  output logic                              calc_error,
  output logic [1:0]                        outcome,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [mvrh_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [mvrh_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import mvrh_pkg::*;

  cmd_t  cmd;
  stat_t st;

  assign cfg_ready = 1'b1;

  mvrh_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  mvrh_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .distance_cm (distance_cm),
    .stamp_us    (stamp_us),
    .cfg_valid   (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .velocity    (velocity),
    .calc_error  (calc_error),
    .outcome     (outcome)
  );

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted a word while busy");

  a_few_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && outcome == OUT_FEW |-> velocity == '0)
    else $error("too-few result not zero");

  a_still_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && outcome == OUT_STILL |-> velocity == '0 && !calc_error)
    else $error("still result wrong");

  a_meas_no_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && outcome == OUT_MEAS |-> !calc_error)
    else $error("measured result flags error");

endmodule

// ----- rtl/mvrh_ctrl.sv -----
// Controller state machine for the median velocity core.
// Depends on mvrh_pkg; drives mvrh_dp through cmd_t, watches stat_t.
module mvrh_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  mvrh_pkg::stat_t st,
  output mvrh_pkg::cmd_t  cmd
);
  import mvrh_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_valid) state_next = S_START;
      S_START:  state_next = st.few ? S_FINISH : S_ADDR;
      S_ADDR:   state_next = st.loop_go ? S_CHK : S_SORT;
      S_CHK:    state_next = st.gap_ok ? S_MUL : S_ADDR;
      S_MUL:    state_next = S_DIV;
      S_DIV:    if (st.div_last) state_next = S_STORE;
      S_STORE:  state_next = S_ADDR;
      S_SORT:   if (st.sort_last) state_next = S_FINISH;
      S_FINISH: if (st.out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_START:  ;
      S_ADDR:   cmd.rd = st.loop_go;
      S_CHK: begin
        cmd.take = st.gap_ok;
        cmd.skip = !st.gap_ok;
      end
      S_MUL:    cmd.mul = 1'b1;
      S_DIV:    cmd.div = 1'b1;
      S_STORE:  cmd.store = 1'b1;
      S_SORT:   cmd.sort = 1'b1;
      S_FINISH: cmd.finish = st.out_free;
      default:  ;
    endcase
  end

endmodule

// ----- rtl/mvrh_dp.sv -----
// Datapath: frame history memory, pair check, multiply, serial divider,
// sort network, result logic and output register. Depends on mvrh_pkg.
module mvrh_dp (
  input  logic                            clk,
  input  logic                            rst,
  input  mvrh_pkg::cmd_t                  cmd,
  output mvrh_pkg::stat_t                 st,
  input  logic [mvrh_pkg::DIST_W-1:0]     distance_cm,
  input  logic [mvrh_pkg::STAMP_W-1:0]    stamp_us,
  input  logic                            cfg_valid,
  input  logic [mvrh_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mvrh_pkg::CFG_DATA_W-1:0] cfg_data,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic signed [mvrh_pkg::VEL_W-1:0] velocity,
  output logic                            calc_error,
  output logic [1:0]                      outcome
);
  import mvrh_pkg::*;

  logic [DIST_W+STAMP_W-1:0] mem [HIST_DEPTH];
  logic [DIST_W+STAMP_W-1:0] rd_word;
  logic [PTR_W-1:0]   head, head_next;
  logic [FRM_W-1:0]   frames;
  logic [FRM_W-1:0]   idx;
  logic [NP_W-1:0]    npairs;
  logic [NP_W-1:0]    nsmall;
  logic [DIST_W-1:0]  new_d;
  logic [STAMP_W-1:0] new_s;
  logic [DDB_W-1:0]   ddb;
  logic [VDB_W-1:0]   vdb;
  logic signed [VEL_W-1:0] prev_vel;
  logic [7:0]         fail_cnt;
  logic               err_flag;

  logic [DIST_W-1:0]  abs_dd;
  logic               neg;
  logic [STAMP_W-1:0] gap_r;
  logic [PROD_W-1:0]  quo;
  logic [STAMP_W-1:0] rem;
  logic [DCNT_W-1:0]  dcnt;
  logic [SCNT_W-1:0]  scnt;
  logic signed [VEL_W-1:0] vals [MAX_PAIRS];
  logic signed [VEL_W-1:0] vals_sw [MAX_PAIRS];

  logic [DIST_W-1:0]  old_d;
  logic [STAMP_W-1:0] old_s, gap;
  logic [DIST_W:0]    dd;
  logic [DIST_W-1:0]  ad;
  logic [STAMP_W:0]   sh;
  logic [PTR_W-1:0]   rd_addr;

  assign head_next = head + PTR_W'(1);
  assign rd_addr   = head - idx[PTR_W-1:0];
  assign old_d     = rd_word[DIST_W+STAMP_W-1:STAMP_W];
  assign old_s     = rd_word[STAMP_W-1:0];
  assign gap       = new_s - old_s;
  assign dd        = {1'b0, new_d} - {1'b0, old_d};
  assign ad        = dd[DIST_W] ? DIST_W'(-dd) : dd[DIST_W-1:0];
  assign sh        = {rem, quo[PROD_W-1]};

  assign st.few       = frames < FRM_W'(MIN_FRAMES);
  assign st.loop_go   = (idx < frames) && (idx < FRM_W'(HIST_DEPTH))
                        && (npairs < NP_W'(MAX_PAIRS));
  assign st.gap_ok    = (gap > GAP_LOW) && (gap < GAP_HIGH);
  assign st.div_last  = dcnt == DCNT_W'(PROD_W - 1);
  assign st.sort_last = scnt == SCNT_W'(MAX_PAIRS - 1);
  assign st.out_free  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.load) mem[head_next] <= {distance_cm, stamp_us};
    if (cmd.rd)   rd_word <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ddb <= DDB_RESET;
      vdb <= VDB_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == REG_DIST_DB) ddb <= cfg_data[DDB_W-1:0];
      if (cfg_index == REG_VEL_DB)  vdb <= cfg_data[VDB_W-1:0];
    end
  end

  // odd-even transposition pass
  always_comb begin
    for (int k = 0; k < MAX_PAIRS; k++) vals_sw[k] = vals[k];
    for (int k = 0; k < MAX_PAIRS - 1; k++) begin
      if ((k % 2) == int'(scnt[0]) && vals[k] > vals[k+1]) begin
        vals_sw[k]   = vals[k+1];
        vals_sw[k+1] = vals[k];
      end
    end
  end

  logic signed [VEL_W-1:0] med, med_db;
  logic [VEL_W:0]          med_mag;
  logic                    still;
  assign med     = vals[npairs >> 1];
  assign med_mag = med[VEL_W-1] ? (VEL_W+1)'(-{med[VEL_W-1], med})
                                : (VEL_W+1)'({1'b0, med});
  assign med_db  = (med_mag <= (VEL_W+1)'({vdb, 4'b0})) ? '0 : med;
  assign still   = nsmall >= (npairs >> 1) + NP_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      head      <= '0;
      frames    <= '0;
      prev_vel  <= '0;
      fail_cnt  <= '0;
      err_flag  <= 1'b0;
      out_valid <= 1'b0;
      idx       <= '0;
      npairs    <= '0;
      nsmall    <= '0;
      dcnt      <= '0;
      scnt      <= '0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (cmd.load) begin
        head   <= head_next;
        new_d  <= distance_cm;
        new_s  <= stamp_us;
        if (frames < FRM_W'(HIST_DEPTH)) frames <= frames + FRM_W'(1);
        idx    <= FRM_W'(2);
        npairs <= '0;
        nsmall <= '0;
        scnt   <= '0;
        for (int k = 0; k < MAX_PAIRS; k++) vals[k] <= {1'b0, {(VEL_W-1){1'b1}}};
      end
      if (cmd.skip) idx <= idx + FRM_W'(2);
      if (cmd.take) begin
        abs_dd <= ad;
        neg    <= dd[DIST_W];
        gap_r  <= gap;
        if ({{(DDB_W){1'b0}}, ad} <= {{(DIST_W){1'b0}}, ddb}) nsmall <= nsmall + NP_W'(1);
      end
      if (cmd.mul) begin
        quo  <= PROD_W'(abs_dd) * PROD_W'(SCALE_FIX);
        rem  <= '0;
        dcnt <= '0;
      end
      if (cmd.div) begin
        dcnt <= dcnt + DCNT_W'(1);
        if (sh >= {1'b0, gap_r}) begin
          rem <= STAMP_W'(sh - {1'b0, gap_r});
          quo <= {quo[PROD_W-2:0], 1'b1};
        end else begin
          rem <= sh[STAMP_W-1:0];
          quo <= {quo[PROD_W-2:0], 1'b0};
        end
      end
      if (cmd.store) begin
        vals[npairs] <= neg ? -VEL_W'(quo[VEL_W-1:0]) : VEL_W'(quo[VEL_W-1:0]);
        npairs <= npairs + NP_W'(1);
        idx    <= idx + FRM_W'(2);
      end
      if (cmd.sort) begin
        scnt <= scnt + SCNT_W'(1);
        for (int k = 0; k < MAX_PAIRS; k++) vals[k] <= vals_sw[k];
      end
      if (cmd.finish) begin
        out_valid <= 1'b1;
        priority if (st.few) begin
          velocity   <= '0;
          calc_error <= err_flag;
          outcome    <= OUT_FEW;
        end else if (npairs == '0) begin
          velocity <= prev_vel;
          outcome  <= OUT_NONE;
          if (fail_cnt < FAIL_MAX) begin
            fail_cnt   <= fail_cnt + 8'd1;
            err_flag   <= (fail_cnt + 8'd1) > FAIL_LIMIT;
            calc_error <= (fail_cnt + 8'd1) > FAIL_LIMIT;
          end else begin
            err_flag   <= 1'b1;
            calc_error <= 1'b1;
          end
        end else if (still) begin
          velocity   <= '0;
          prev_vel   <= '0;
          fail_cnt   <= '0;
          err_flag   <= 1'b0;
          calc_error <= 1'b0;
          outcome    <= OUT_STILL;
        end else begin
          velocity   <= med_db;
          prev_vel   <= med_db;
          fail_cnt   <= '0;
          err_flag   <= 1'b0;
          calc_error <= 1'b0;
          outcome    <= OUT_MEAS;
        end
      end
    end
  end

endmodule

// ----- test/testbench.sv -----
// Testbench for median_velocity_from_range_history_core: directed table then
// random range frames, checked against an in-bench velocity predictor.
// Depends on mvrh_pkg and the core RTL.
`timescale 1ns / 100ps

module testbench;
  import mvrh_pkg::*;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [DIST_W-1:0] distance_cm = '0;
  logic [STAMP_W-1:0] stamp_us = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [VEL_W-1:0] velocity;
  logic calc_error;
  logic [1:0] outcome;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  median_velocity_from_range_history_core dut (.*);

  always #2 clk = ~clk;

  typedef struct {
    logic signed [VEL_W-1:0] vel;
    logic err;
    outcome_t code;
  } vel_word_t;

  typedef struct {
    logic [DIST_W-1:0] range_cm;
    logic [STAMP_W-1:0] stamp;
    bit fixed;
    logic signed [VEL_W-1:0] vel;
    outcome_t code;
  } frame_row_t;

  logic [DIST_W-1:0] range_hist [HIST_DEPTH];
  logic [STAMP_W-1:0] stamp_hist [HIST_DEPTH];
  int frames_seen;
  logic signed [VEL_W-1:0] last_vel;
  int fail_cnt;
  bit err_flag;
  logic [DDB_W-1:0] dist_db;
  logic [VDB_W-1:0] vel_db;

  vel_word_t pending_vel[$];
  int failures = 0;
  bit quiet = 1'b0;
  bit hold_off = 1'b0;
  longint cycles = 0;

  function automatic vel_word_t predict_velocity(logic [DIST_W-1:0] d,
                                                 logic [STAMP_W-1:0] s);
    vel_word_t r;
    logic signed [VEL_W-1:0] vals [MAX_PAIRS];
    logic signed [VEL_W-1:0] t;
    logic [STAMP_W-1:0] gap;
    longint dd, ad, mag;
    int n, nsmall;
    n = 0;
    nsmall = 0;
    for (int k = HIST_DEPTH - 1; k > 0; k--) begin
      range_hist[k] = range_hist[k-1];
      stamp_hist[k] = stamp_hist[k-1];
    end
    range_hist[0] = d;
    stamp_hist[0] = s;
    if (frames_seen < HIST_DEPTH) frames_seen++;
    r.err = err_flag;
    if (frames_seen < MIN_FRAMES) begin
      r.vel = '0;
      r.code = OUT_FEW;
      return r;
    end
    for (int i = 2; i < frames_seen && n < MAX_PAIRS; i += 2) begin
      gap = stamp_hist[0] - stamp_hist[i];
      if (gap > GAP_LOW && gap < GAP_HIGH) begin
        dd = longint'(range_hist[0]) - longint'(range_hist[i]);
        ad = dd < 0 ? -dd : dd;
        if (ad <= longint'(dist_db)) nsmall++;
        vals[n] = VEL_W'((dd * 16000000) / longint'(gap));
        n++;
      end
    end
    if (n == 0) begin
      if (fail_cnt < 255) fail_cnt++;
      err_flag = fail_cnt > 10;
      r.err = err_flag;
      r.vel = last_vel;
      r.code = OUT_NONE;
      return r;
    end
    fail_cnt = 0;
    err_flag = 1'b0;
    r.err = 1'b0;
    if (nsmall >= n / 2 + 1) begin
      last_vel = '0;
      r.vel = '0;
      r.code = OUT_STILL;
      return r;
    end
    for (int i = 0; i < n - 1; i++)
      for (int j = i + 1; j < n; j++)
        if (vals[i] > vals[j]) begin
          t = vals[i];
          vals[i] = vals[j];
          vals[j] = t;
        end
    t = vals[n/2];
    mag = t < 0 ? -longint'(t) : longint'(t);
    if (mag <= longint'(vel_db) * 16) t = '0;
    last_vel = t;
    r.vel = t;
    r.code = OUT_MEAS;
    return r;
  endfunction

  task automatic send_frame(logic [DIST_W-1:0] d, logic [STAMP_W-1:0] s);
    vel_word_t e;
    @(negedge clk);
    while (!quiet && $urandom_range(99) < 38) @(negedge clk);
    in_valid <= 1'b1;
    distance_cm <= d;
    stamp_us <= s;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    e = predict_velocity(d, s);
    pending_vel.push_back(e);
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    while (pending_vel.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_DIST_DB) dist_db = val[DDB_W-1:0];
    else vel_db = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // receiver
  always @(negedge clk) begin
    if (rst || hold_off) out_ready <= 1'b0;
    else out_ready <= quiet || ($urandom_range(99) >= 38);
  end

  always @(posedge clk) begin
    vel_word_t e;
    cycles <= cycles + 1;
    if (!rst && out_valid && out_ready) begin
      if (pending_vel.size() == 0) begin
        $error("unexpected word: velocity %0d", velocity);
        failures++;
      end else begin
        e = pending_vel.pop_front();
        if (velocity !== e.vel) begin
          $error("velocity expected %0d actual %0d", e.vel, velocity);
          failures++;
        end
        if (calc_error !== e.err) begin
          $error("calc_error expected %0b actual %0b", e.err, calc_error);
          failures++;
        end
        if (outcome !== e.code) begin
          $error("outcome expected %0d actual %0d", e.code, outcome);
          failures++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycles > 3000000) begin
      $display("testbench NOT OK");
      $finish;
    end
  end

  frame_row_t rows [] = '{
    '{16'h0000, 32'h0000_0000, 1, 32'sd0, OUT_FEW},
    '{16'hFFFF, 32'hFFFF_FFFF, 1, 32'sd0, OUT_FEW},
    '{16'h0000, 32'h0000_0BB8, 1, 32'sd0, OUT_FEW},
    '{16'hFFFF, 32'h0000_1770, 1, 32'sd0, OUT_FEW},
    '{16'hFFFF, 32'h0000_2710, 0, 32'sd0, OUT_MEAS},
    '{16'hFFFF, 32'h0000_2AF8, 0, 32'sd0, OUT_MEAS},
    '{16'hFFFF, 32'h0000_2EE0, 0, 32'sd0, OUT_MEAS},
    '{16'h0000, 32'h0000_32C8, 0, 32'sd0, OUT_MEAS},
    '{16'h0000, 32'h0000_32C8, 0, 32'sd0, OUT_MEAS},
    '{16'h0000, 32'h0000_32C9, 0, 32'sd0, OUT_MEAS},
    '{16'h1234, 32'h8000_0000, 0, 32'sd0, OUT_MEAS},
    '{16'h1234, 32'h8000_03E8, 0, 32'sd0, OUT_MEAS},
    '{16'h1234, 32'h8000_07D0, 0, 32'sd0, OUT_MEAS},
    '{16'h1236, 32'h8000_0FA0, 0, 32'sd0, OUT_MEAS},
    '{16'h1237, 32'h8000_1770, 0, 32'sd0, OUT_MEAS},
    '{16'h0100, 32'h8000_C350, 0, 32'sd0, OUT_MEAS},
    '{16'h0100, 32'h8001_86A0, 0, 32'sd0, OUT_MEAS},
    '{16'h0090, 32'h8001_8A88, 0, 32'sd0, OUT_MEAS},
    '{16'h0080, 32'h8001_8E70, 0, 32'sd0, OUT_MEAS},
    '{16'h0070, 32'h8001_9258, 0, 32'sd0, OUT_MEAS}
  };

  task automatic random_phase(int count);
    logic [DIST_W-1:0] d;
    logic [STAMP_W-1:0] s;
    int speed;
    d = 16'($urandom);
    s = $urandom;
    speed = $urandom_range(400) - 200;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(99) < 85) begin
        // well formed track: stamps 1.5..12 ms apart
        s = s + $urandom_range(12000, 1500);
        if ($urandom_range(9) < 2) speed = $urandom_range(400) - 200;
        d = d + DIST_W'(speed) + DIST_W'($urandom_range(4)) - DIST_W'(2);
      end else begin
        case ($urandom_range(3))
          0: s = s + $urandom_range(1000);
          1: s = s + $urandom_range(200000, 50000);
          2: s = $urandom;
          default: d = 16'($urandom);
        endcase
      end
      send_frame(d, s);
    end
  endtask

  initial begin
    vel_word_t e;
    for (int k = 0; k < HIST_DEPTH; k++) begin
      range_hist[k] = '0;
      stamp_hist[k] = '0;
    end
    frames_seen = 0;
    last_vel = '0;
    fail_cnt = 0;
    err_flag = 1'b0;
    dist_db = DDB_RESET;
    vel_db = VDB_RESET;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (rows[r]) begin
      send_frame(rows[r].range_cm, rows[r].stamp);
      e = pending_vel[$];
      if (rows[r].fixed && (e.vel !== rows[r].vel || e.code !== rows[r].code)) begin
        $error("table row %0d: velocity expected %0d outcome %0d", r, rows[r].vel,
               rows[r].code);
        failures++;
      end
    end
    // frames with no valid pairs: drive the failure count past the flag
    for (int k = 0; k < 14; k++) send_frame(16'($urandom), 32'h9000_0000 + k * 10);

    random_phase(250);

    // receiver holds off while frames keep coming
    fork
      begin
        hold_off = 1'b1;
        repeat (2000) @(negedge clk);
        hold_off = 1'b0;
      end
      random_phase(10);
    join

    write_reg(REG_DIST_DB, CFG_DATA_W'(0));
    write_reg(REG_VEL_DB, CFG_DATA_W'(0));
    random_phase(200);
    write_reg(REG_DIST_DB, CFG_DATA_W'(255));
    write_reg(REG_VEL_DB, CFG_DATA_W'(1023));
    random_phase(200);
    quiet = 1'b1;
    write_reg(REG_DIST_DB, CFG_DATA_W'($urandom_range(20)));
    write_reg(REG_VEL_DB, CFG_DATA_W'($urandom_range(300)));
    random_phase(200);
    quiet = 1'b0;
    write_reg(REG_DIST_DB, CFG_DATA_W'(8'hAA));
    write_reg(REG_VEL_DB, CFG_DATA_W'(10'h155));
    random_phase(250);

    while (pending_vel.size() != 0) @(negedge clk);
    repeat (300) @(negedge clk);
    if (failures == 0) $display("testbench OK");
    else $display("testbench NOT OK");
    $finish;
  end

endmodule
